[rtl/qslp_pkg.sv]
// Shared types, constants and the arctangent table for the quaternion slerp pipeline.
package qslp_pkg;

	localparam int CB        = 16;          // component width
	localparam int FRAC      = CB - 2;      // fraction bits of a component
	localparam int DOT_SHIFT = 30 - 2 * FRAC;
	localparam int DW        = 32;          // clamped dot product, Q.30 signed
	localparam int CW        = 34;          // CORDIC datapath width
	localparam int SNW       = 31;          // sines and square roots, Q.30 unsigned
	localparam int UW        = 48;          // weighted sum, signed
	localparam int AW        = 47;          // magnitude of the weighted sum
	localparam int VW        = 30;          // magnitude after range shift
	localparam int KW        = 5;           // range shift amount
	localparam int EW        = 45;          // epsilon times sin(alpha)
	localparam int NW        = 45;          // divider numerator
	localparam int QW        = FRAC + 1;    // quotient bits

	localparam logic [15:0] BLEND_ONE   = 16'd32768;
	localparam logic [31:0] PI_Q30      = 32'd3373259426;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic [31:0] INV_GAIN    = 32'd652032874;
	localparam logic [31:0] ONE_Q30     = 32'd1073741824;
	localparam logic [13:0] EPS_Q30     = 14'd10737;

	typedef enum logic [1:0] {
		ST_INTERP   = 2'd0,
		ST_NEAR     = 2'd1,
		ST_OPPOSITE = 2'd2
	} status_t;

	typedef logic [3:0][CB-1:0] quat_t;

	// context carried through the sin(alpha) square root
	typedef struct packed {
		quat_t                 f;
		quat_t                 g;
		logic [15:0]           t;
		logic signed [DW-1:0]  d;
	} sb_a_t;

	// context carried through the arc CORDIC
	typedef struct packed {
		quat_t          f;
		quat_t          g;
		logic [15:0]    t;
		logic           dpos;
		logic           szero;
		logic [EW-1:0]  eps_s;
	} sb_b_t;

	// context carried through the sine CORDIC
	typedef struct packed {
		quat_t          f;
		quat_t          g;
		logic           near;
		logic           opp;
		logic [EW-1:0]  eps_s;
	} sb_c_t;

	// context carried through the length square root
	typedef struct packed {
		quat_t                 f;
		logic [3:0]            sgn;
		logic [3:0][VW-1:0]    v;
		logic [KW-1:0]         k;
		logic [EW-1:0]         eps_s;
		logic                  near;
		logic                  opp;
	} sb_d_t;

	// context carried through the divider
	typedef struct packed {
		quat_t       f;
		logic [3:0]  sgn;
		logic        near;
		logic        opp;
		logic        vanish;
	} sb_e_t;

	// atan(2^-i) in Q.30
	function automatic logic signed [CW-1:0] arc_q30(input int unsigned idx);
		logic [31:0] r;
		case (idx)
			0:  r = 32'h3243F6A8;
			1:  r = 32'h1DAC6705;
			2:  r = 32'h0FADBAFC;
			3:  r = 32'h07F56EA6;
			4:  r = 32'h03FEAB76;
			5:  r = 32'h01FFD55B;
			6:  r = 32'h00FFFAAA;
			7:  r = 32'h007FFF55;
			8:  r = 32'h003FFFEA;
			9:  r = 32'h001FFFFD;
			10: r = 32'h000FFFFF;
			11: r = 32'h0007FFFF;
			12: r = 32'h0003FFFF;
			13: r = 32'h0001FFFF;
			14: r = 32'h0000FFFF;
			15: r = 32'h00007FFF;
			16: r = 32'h00003FFF;
			17: r = 32'h00001FFF;
			18: r = 32'h00000FFF;
			19: r = 32'h000007FF;
			20: r = 32'h000003FF;
			21: r = 32'h000001FF;
			22: r = 32'h000000FF;
			23: r = 32'h0000007F;
			24: r = 32'h0000003F;
			25: r = 32'h0000001F;
			26: r = 32'h0000000F;
			27: r = 32'h00000007;
			28: r = 32'h00000003;
			29: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return $signed(CW'(r));
	endfunction

endpackage

[rtl/qslp_isqrt.sv]
// Pipelined integer square root, one result bit per stage, with a context word alongside.
module qslp_isqrt #(
	parameter int W  = 62,
	parameter int SW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [W-1:0]   in_rad,
	input  logic [SW-1:0]  in_side,
	output logic           out_valid,
	output logic [W/2-1:0] out_root,
	output logic [SW-1:0]  out_side
);
	localparam int N = W / 2;

	logic           vld_s  [0:N];
	logic [W-1:0]   src_s  [0:N];
	logic [N+1:0]   rem_s  [0:N];
	logic [N-1:0]   root_s [0:N];
	logic [SW-1:0]  side_s [0:N];

	assign vld_s[0]  = in_valid;
	assign src_s[0]  = in_rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [N+3:0] acc;
		logic [N+3:0] trial;
		logic         ge;

		// bring down two bits, try the next root bit
		assign acc   = {rem_s[k], src_s[k][W-1 -: 2]};
		assign trial = (N+4)'({root_s[k], 2'b01});
		assign ge    = acc >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? (N+2)'(acc - trial) : (N+2)'(acc);
				root_s[k+1] <= {root_s[k][N-2:0], ge};
				src_s[k+1]  <= src_s[k] << 2;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_root  = root_s[N];
	assign out_side  = side_s[N];

endmodule

[rtl/qslp_cordic.sv]
// Pipelined CORDIC, one micro-rotation per stage, vectoring or rotation mode.
module qslp_cordic import qslp_pkg::*; #(
	parameter int   STEPS  = 16,
	parameter int   LANES  = 1,
	parameter bit   VECTOR = 1'b1,
	parameter int   SW     = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [CW-1:0] in_x [LANES],
	input  logic signed [CW-1:0] in_y [LANES],
	input  logic signed [CW-1:0] in_z [LANES],
	input  logic [SW-1:0]        in_side,
	output logic                 out_valid,
	output logic signed [CW-1:0] out_x [LANES],
	output logic signed [CW-1:0] out_y [LANES],
	output logic signed [CW-1:0] out_z [LANES],
	output logic [SW-1:0]        out_side
);
	logic                 vld_s  [0:STEPS];
	logic [SW-1:0]        side_s [0:STEPS];
	logic signed [CW-1:0] x_s    [0:STEPS][LANES];
	logic signed [CW-1:0] y_s    [0:STEPS][LANES];
	logic signed [CW-1:0] z_s    [0:STEPS][LANES];

	assign vld_s[0]  = in_valid;
	assign side_s[0] = in_side;
	assign x_s[0]    = in_x;
	assign y_s[0]    = in_y;
	assign z_s[0]    = in_z;

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i+1] <= side_s[i];
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic signed [CW-1:0] dx, dy;
			logic                 up;

			// vectoring drives y to zero, rotation drives z to zero
			assign dx = x_s[i][l] >>> i;
			assign dy = y_s[i][l] >>> i;
			assign up = VECTOR ? !(y_s[i][l] > 0) : (z_s[i][l] >= 0);

			always_ff @(posedge clk) begin
				if (en) begin
					if (up) begin
						x_s[i+1][l] <= x_s[i][l] - dy;
						y_s[i+1][l] <= y_s[i][l] + dx;
						z_s[i+1][l] <= z_s[i][l] - arc_q30(i);
					end else begin
						x_s[i+1][l] <= x_s[i][l] + dy;
						y_s[i+1][l] <= y_s[i][l] - dx;
						z_s[i+1][l] <= z_s[i][l] + arc_q30(i);
					end
				end
			end
		end
	end

	assign out_valid = vld_s[STEPS];
	assign out_side  = side_s[STEPS];
	assign out_x     = x_s[STEPS];
	assign out_y     = y_s[STEPS];
	assign out_z     = z_s[STEPS];

endmodule

[rtl/quaternion_slerp.sv]
// Quaternion slerp pipeline: dot, arc, sine weights, weighted sum, normalize.
// Built from registered stages around two 31-stage square roots, two CORDIC pipelines
// and a 15-stage divider.
// Throughput: one item per cycle; the whole pipeline advances whenever the output
// register is empty or being taken.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
module quaternion_slerp import qslp_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// from_w, from_x, from_y, from_z, to_w, to_x, to_y, to_z, blend (16 bits each)
	input  logic [143:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_w, out_x, out_y, out_z (16 bits each)
	output logic [63:0]  m_axis_tdata,
	// path_status
	output logic [1:0]   m_axis_tuser
);

	logic en;
	logic v_out_q;

	// advance all stages together unless the output item is stalled
	assign en            = !v_out_q || m_axis_tready;
	assign s_axis_tready = en;

	// ---------------- stage 1: capture, saturate blend
	logic        v_s1;
	quat_t       f_s1, g_s1;
	logic [15:0] t_s1;
	logic [15:0] blend_in;

	assign blend_in = s_axis_tdata[8*CB +: 16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				f_s1[i] <= s_axis_tdata[i*CB +: CB];
				g_s1[i] <= s_axis_tdata[(4+i)*CB +: CB];
			end
			t_s1 <= (blend_in > BLEND_ONE) ? BLEND_ONE : blend_in;
		end
	end

	// ---------------- stage 2: dot products
	logic                  v_s2;
	logic signed [2*CB-1:0] p_s2 [4];
	quat_t                 f_s2, g_s2;
	logic [15:0]           t_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++)
				p_s2[i] <= $signed(f_s1[i]) * $signed(g_s1[i]);
			f_s2 <= f_s1;
			g_s2 <= g_s1;
			t_s2 <= t_s1;
		end
	end

	// ---------------- stage 3: sum and clamp to [-1, 1]
	logic                 v_s3;
	logic signed [DW-1:0] d_s3;
	quat_t                f_s3, g_s3;
	logic [15:0]          t_s3;
	logic signed [35:0]   dsum;
	logic signed [DW-1:0] dclamp;

	always_comb begin
		dsum = '0;
		for (int i = 0; i < 4; i++)
			dsum = dsum + (36'(p_s2[i]) <<< DOT_SHIFT);
		if (dsum > $signed(36'(ONE_Q30)))
			dclamp = $signed(DW'(ONE_Q30));
		else if (dsum < -$signed(36'(ONE_Q30)))
			dclamp = -$signed(DW'(ONE_Q30));
		else
			dclamp = DW'(dsum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s3 <= dclamp;
			f_s3 <= f_s2;
			g_s3 <= g_s2;
			t_s3 <= t_s2;
		end
	end

	// ---------------- stage 4: 1 - d^2
	logic               v_s4;
	logic [61:0]        rad_s4;
	sb_a_t              sba_s4;
	logic signed [63:0] dsq;

	assign dsq = d_s3 * d_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s4   <= (62'd1 << 60) - dsq[61:0];
			sba_s4.f <= f_s3;
			sba_s4.g <= g_s3;
			sba_s4.t <= t_s3;
			sba_s4.d <= d_s3;
		end
	end

	// ---------------- sin(alpha) = sqrt(1 - d^2)
	logic                  sq_vld;
	logic [SNW-1:0]        sq_root;
	logic [$bits(sb_a_t)-1:0] sq_side;
	sb_a_t                 sba_o;

	qslp_isqrt #(.W(62), .SW($bits(sb_a_t))) u_sqrt_sin (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.in_rad   (rad_s4),
		.in_side  (sba_s4),
		.out_valid(sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	assign sba_o = sb_a_t'(sq_side);

	// ---------------- stage 5: set up the arc vector
	logic                 v_s5;
	logic signed [CW-1:0] vx_s5 [1];
	logic signed [CW-1:0] vy_s5 [1];
	logic signed [CW-1:0] vz_s5 [1];
	sb_b_t                sbb_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= sq_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// negative dot: start rotated by -90 degrees at pi/2
			if (sba_o.d >= 0) begin
				vx_s5[0] <= CW'(sba_o.d);
				vy_s5[0] <= $signed(CW'(sq_root));
				vz_s5[0] <= '0;
			end else begin
				vx_s5[0] <= $signed(CW'(sq_root));
				vy_s5[0] <= -CW'(sba_o.d);
				vz_s5[0] <= $signed(CW'(HALF_PI_Q30));
			end
			sbb_s5.f     <= sba_o.f;
			sbb_s5.g     <= sba_o.g;
			sbb_s5.t     <= sba_o.t;
			sbb_s5.dpos  <= sba_o.d > 0;
			sbb_s5.szero <= sq_root == '0;
			sbb_s5.eps_s <= EW'(EPS_Q30) * EW'(sq_root);
		end
	end

	// ---------------- alpha = atan2(s, d)
	logic                     arc_vld;
	logic signed [CW-1:0]     arc_z [1];
	logic [$bits(sb_b_t)-1:0] arc_side;
	sb_b_t                    sbb_o;

	qslp_cordic #(
		.STEPS (CORDIC_STEPS),
		.LANES (1),
		.VECTOR(1'b1),
		.SW    ($bits(sb_b_t))
	) u_cordic_arc (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s5),
		.in_x     (vx_s5),
		.in_y     (vy_s5),
		.in_z     (vz_s5),
		.in_side  (sbb_s5),
		.out_valid(arc_vld),
		.out_x    (),
		.out_y    (),
		.out_z    (arc_z),
		.out_side (arc_side)
	);

	assign sbb_o = sb_b_t'(arc_side);

	// ---------------- stage 6: clamp alpha, classify
	logic          v_s6;
	logic [31:0]   alpha_s6;
	logic          near_s6, opp_s6;
	quat_t         f_s6, g_s6;
	logic [15:0]   t_s6;
	logic [EW-1:0] eps_s6;
	logic [31:0]   alpha_c;

	always_comb begin
		if (sbb_o.szero)
			alpha_c = sbb_o.dpos ? 32'd0 : PI_Q30;
		else if (arc_z[0] < 0)
			alpha_c = 32'd0;
		else if (arc_z[0] > $signed(CW'(PI_Q30)))
			alpha_c = PI_Q30;
		else
			alpha_c = arc_z[0][31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= arc_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s6 <= alpha_c;
			near_s6  <= alpha_c < 32'(EPS_Q30);
			opp_s6   <= sbb_o.szero;
			f_s6     <= sbb_o.f;
			g_s6     <= sbb_o.g;
			t_s6     <= sbb_o.t;
			eps_s6   <= sbb_o.eps_s;
		end
	end

	// ---------------- stage 7: theta2 = alpha * t
	logic          v_s7;
	logic [31:0]   alpha_s7, th2_s7;
	logic [47:0]   th_prod;
	sb_c_t         sbc_s7;

	assign th_prod = 48'(alpha_s6) * 48'(t_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s7     <= alpha_s6;
			th2_s7       <= th_prod[46:15];
			sbc_s7.f     <= f_s6;
			sbc_s7.g     <= g_s6;
			sbc_s7.near  <= near_s6;
			sbc_s7.opp   <= opp_s6;
			sbc_s7.eps_s <= eps_s6;
		end
	end

	// ---------------- stage 8: theta1, fold both angles into [0, pi/2]
	logic                 v_s8;
	logic signed [CW-1:0] rx_s8 [2];
	logic signed [CW-1:0] ry_s8 [2];
	logic signed [CW-1:0] rz_s8 [2];
	sb_c_t                sbc_s8;
	logic [31:0]          th1, fold1, fold2;

	assign th1   = alpha_s7 - th2_s7;
	assign fold1 = (th1 > HALF_PI_Q30) ? PI_Q30 - th1 : th1;
	assign fold2 = (th2_s7 > HALF_PI_Q30) ? PI_Q30 - th2_s7 : th2_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (en) v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				rx_s8[l] <= $signed(CW'(INV_GAIN));
				ry_s8[l] <= '0;
			end
			rz_s8[0] <= $signed(CW'(fold1));
			rz_s8[1] <= $signed(CW'(fold2));
			sbc_s8   <= sbc_s7;
		end
	end

	// ---------------- sines of both angles
	logic                     sin_vld;
	logic signed [CW-1:0]     sin_y [2];
	logic [$bits(sb_c_t)-1:0] sin_side;
	sb_c_t                    sbc_o;

	qslp_cordic #(
		.STEPS (CORDIC_STEPS),
		.LANES (2),
		.VECTOR(1'b0),
		.SW    ($bits(sb_c_t))
	) u_cordic_sin (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s8),
		.in_x     (rx_s8),
		.in_y     (ry_s8),
		.in_z     (rz_s8),
		.in_side  (sbc_s8),
		.out_valid(sin_vld),
		.out_x    (),
		.out_y    (sin_y),
		.out_z    (),
		.out_side (sin_side)
	);

	assign sbc_o = sb_c_t'(sin_side);

	// ---------------- stage 9: clamp sines to [0, 1]
	logic           v_s9;
	logic [SNW-1:0] sn_s9 [2];
	sb_c_t          sbc_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (en) v_s9 <= sin_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				if (sin_y[l] < 0)
					sn_s9[l] <= '0;
				else if (sin_y[l] > $signed(CW'(ONE_Q30)))
					sn_s9[l] <= SNW'(ONE_Q30);
				else
					sn_s9[l] <= SNW'(sin_y[l]);
			end
			sbc_s9 <= sbc_o;
		end
	end

	// ---------------- stage 10: weight both quaternions
	logic                 v_s10;
	logic signed [UW-1:0] pf_s10 [4];
	logic signed [UW-1:0] pg_s10 [4];
	quat_t                f_s10;
	logic                 near_s10, opp_s10;
	logic [EW-1:0]        eps_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s10 <= 1'b0;
		else if (en) v_s10 <= v_s9;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				pf_s10[i] <= UW'($signed({1'b0, sn_s9[0]})) * UW'($signed(sbc_s9.f[i]));
				pg_s10[i] <= UW'($signed({1'b0, sn_s9[1]})) * UW'($signed(sbc_s9.g[i]));
			end
			f_s10    <= sbc_s9.f;
			near_s10 <= sbc_s9.near;
			opp_s10  <= sbc_s9.opp;
			eps_s10  <= sbc_s9.eps_s;
		end
	end

	// ---------------- stage 11: weighted sum
	logic                 v_s11;
	logic signed [UW-1:0] u_s11 [4];
	quat_t                f_s11;
	logic                 near_s11, opp_s11;
	logic [EW-1:0]        eps_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s11 <= 1'b0;
		else if (en) v_s11 <= v_s10;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++)
				u_s11[i] <= pf_s10[i] + pg_s10[i];
			f_s11    <= f_s10;
			near_s11 <= near_s10;
			opp_s11  <= opp_s10;
			eps_s11  <= eps_s10;
		end
	end

	// ---------------- stage 12: magnitudes and signs
	logic          v_s12;
	logic [AW-1:0] a_s12 [4];
	logic [3:0]    sgn_s12;
	quat_t         f_s12;
	logic          near_s12, opp_s12;
	logic [EW-1:0] eps_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s12 <= 1'b0;
		else if (en) v_s12 <= v_s11;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				a_s12[i]   <= (u_s11[i] < 0) ? AW'(-u_s11[i]) : AW'(u_s11[i]);
				sgn_s12[i] <= u_s11[i] < 0;
			end
			f_s12    <= f_s11;
			near_s12 <= near_s11;
			opp_s12  <= opp_s11;
			eps_s12  <= eps_s11;
		end
	end

	// ---------------- stage 13: range shift from the widest magnitude
	logic          v_s13;
	logic [AW-1:0] a_s13 [4];
	logic [KW-1:0] k_s13;
	logic [3:0]    sgn_s13;
	quat_t         f_s13;
	logic          near_s13, opp_s13;
	logic [EW-1:0] eps_s13;
	logic [AW-1:0] a_or;
	logic [KW-1:0] k_c;

	always_comb begin
		a_or = a_s12[0] | a_s12[1] | a_s12[2] | a_s12[3];
		k_c  = '0;
		for (int b = VW; b < AW; b++)
			if (a_or[b]) k_c = KW'(b - VW + 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s13 <= 1'b0;
		else if (en) v_s13 <= v_s12;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s13    <= a_s12;
			k_s13    <= k_c;
			sgn_s13  <= sgn_s12;
			f_s13    <= f_s12;
			near_s13 <= near_s12;
			opp_s13  <= opp_s12;
			eps_s13  <= eps_s12;
		end
	end

	// ---------------- stage 14: shifted magnitudes
	logic          v_s14;
	logic [VW-1:0] vm_s14 [4];
	logic [KW-1:0] k_s14;
	logic [3:0]    sgn_s14;
	quat_t         f_s14;
	logic          near_s14, opp_s14;
	logic [EW-1:0] eps_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s14 <= 1'b0;
		else if (en) v_s14 <= v_s13;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++)
				vm_s14[i] <= VW'(a_s13[i] >> k_s13);
			k_s14    <= k_s13;
			sgn_s14  <= sgn_s13;
			f_s14    <= f_s13;
			near_s14 <= near_s13;
			opp_s14  <= opp_s13;
			eps_s14  <= eps_s13;
		end
	end

	// ---------------- stage 15: squares
	logic            v_s15;
	logic [2*VW-1:0] sq_s15 [4];
	sb_d_t           sbd_s15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s15 <= 1'b0;
		else if (en) v_s15 <= v_s14;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				sq_s15[i]    <= vm_s14[i] * vm_s14[i];
				sbd_s15.v[i] <= vm_s14[i];
			end
			sbd_s15.f     <= f_s14;
			sbd_s15.sgn   <= sgn_s14;
			sbd_s15.k     <= k_s14;
			sbd_s15.eps_s <= eps_s14;
			sbd_s15.near  <= near_s14;
			sbd_s15.opp   <= opp_s14;
		end
	end

	// ---------------- stage 16: sum of squares
	logic        v_s16;
	logic [61:0] ss_s16;
	sb_d_t       sbd_s16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s16 <= 1'b0;
		else if (en) v_s16 <= v_s15;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s16  <= 62'(sq_s15[0]) + 62'(sq_s15[1]) + 62'(sq_s15[2]) + 62'(sq_s15[3]);
			sbd_s16 <= sbd_s15;
		end
	end

	// ---------------- length
	logic                     ln_vld;
	logic [SNW-1:0]           ln_root;
	logic [$bits(sb_d_t)-1:0] ln_side;
	sb_d_t                    sbd_o;

	qslp_isqrt #(.W(62), .SW($bits(sb_d_t))) u_sqrt_len (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s16),
		.in_rad   (ss_s16),
		.in_side  (sbd_s16),
		.out_valid(ln_vld),
		.out_root (ln_root),
		.out_side (ln_side)
	);

	assign sbd_o = sb_d_t'(ln_side);

	// ---------------- stage 17: vanishing test, divider numerators
	logic [63:0] mag;

	assign mag = (64'(ln_root) << sbd_o.k) << (30 - FRAC);

	logic           dv_vld [0:QW];
	logic [NW-1:0]  dv_rem [0:QW][4];
	logic [QW-1:0]  dv_quo [0:QW][4];
	logic [SNW-1:0] dv_len [0:QW];
	sb_e_t          dv_ctx [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_vld[0] <= 1'b0;
		else if (en) dv_vld[0] <= ln_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				dv_rem[0][i] <= (NW'(sbd_o.v[i]) << FRAC) + NW'(ln_root >> 1);
				dv_quo[0][i] <= '0;
			end
			dv_len[0]        <= ln_root;
			dv_ctx[0].f      <= sbd_o.f;
			dv_ctx[0].sgn    <= sbd_o.sgn;
			dv_ctx[0].near   <= sbd_o.near;
			dv_ctx[0].opp    <= sbd_o.opp;
			dv_ctx[0].vanish <= (ln_root == '0) || (mag <= 64'(sbd_o.eps_s));
		end
	end

	// ---------------- restoring divider, one quotient bit per stage
	for (genvar j = 0; j < QW; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_vld[j+1] <= 1'b0;
			else if (en) dv_vld[j+1] <= dv_vld[j];
		end

		for (genvar i = 0; i < 4; i++) begin : g_lane
			logic [NW-1:0] tv;
			logic          ge;

			assign tv = NW'(dv_len[j]) << (QW - 1 - j);
			assign ge = dv_rem[j][i] >= tv;

			always_ff @(posedge clk) begin
				if (en) begin
					dv_rem[j+1][i] <= ge ? dv_rem[j][i] - tv : dv_rem[j][i];
					dv_quo[j+1][i] <= {dv_quo[j][i][QW-2:0], ge};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_len[j+1] <= dv_len[j];
				dv_ctx[j+1] <= dv_ctx[j];
			end
		end
	end

	// ---------------- output register: pick bypass, zero or normalized result
	logic [3:0][CB-1:0] res_c;
	status_t            st_c;
	logic [63:0]        data_q;
	logic [1:0]         user_q;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (dv_ctx[QW].near || dv_ctx[QW].opp)
				res_c[i] = dv_ctx[QW].f[i];
			else if (dv_ctx[QW].vanish)
				res_c[i] = '0;
			else if (dv_ctx[QW].sgn[i])
				res_c[i] = -CB'(dv_quo[QW][i]);
			else
				res_c[i] = CB'(dv_quo[QW][i]);
		end
		if (dv_ctx[QW].near)
			st_c = ST_NEAR;
		else if (dv_ctx[QW].opp)
			st_c = ST_OPPOSITE;
		else
			st_c = ST_INTERP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_out_q <= 1'b0;
		else if (en) v_out_q <= dv_vld[QW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= res_c;
			user_q <= st_c;
		end
	end

	assign m_axis_tvalid = v_out_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = user_q;

endmodule

[rtl/qslp_check.sv]
// Port-level checker for the quaternion slerp pipeline, bound to the top level.
module qslp_check import qslp_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [143:0] s_axis_tdata,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [63:0]  m_axis_tdata,
	input logic [1:0]   m_axis_tuser
);
	localparam logic signed [CB-1:0] UNIT = CB'(1 << FRAC);

	logic in_range;

	// every normalized component lies within [-1, 1]
	always_comb begin
		in_range = 1'b1;
		for (int i = 0; i < 4; i++)
			if ($signed(m_axis_tdata[i*CB +: CB]) > UNIT ||
			    $signed(m_axis_tdata[i*CB +: CB]) < -UNIT)
				in_range = 1'b0;
	end

	// input side is held only while the output item is stalled
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output stall");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output item dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output item changed while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_INTERP |-> in_range)
		else $error("interpolated component outside unit range");

endmodule

bind quaternion_slerp qslp_check u_qslp_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata (s_axis_tdata),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

[verif/tb_quaternion_slerp.sv]
// Self-checking testbench for the quaternion slerp pipeline.
`timescale 1ns / 1ps

module tb_quaternion_slerp;
	import qslp_pkg::*;

	localparam int LATENCY = 127;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int N_RANDOM = 1100;

	localparam logic signed [63:0] ARC_ONE = 64'sd1073741824;
	localparam logic signed [63:0] ARC_PI = 64'sd3373259426;
	localparam logic signed [63:0] ARC_HALF_PI = 64'sd1686629713;
	localparam logic signed [63:0] GAIN_INV = 64'sd652032874;
	localparam logic signed [63:0] TINY_ARC = 64'sd10737;

	typedef struct {
		logic [3:0][15:0] q;
		status_t status;
	} slerp_result_t;

	// floor square root of a 64-bit value
	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// vectoring CORDIC: accumulate the angle of (x, y)
	function automatic logic signed [63:0] arc_angle(input logic signed [63:0] x,
			input logic signed [63:0] y, input logic signed [63:0] z);
		logic signed [63:0] dx, dy;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += 64'(arc_q30(i));
			end else begin
				x -= dx; y += dy; z -= 64'(arc_q30(i));
			end
		end
		return z;
	endfunction

	// rotation CORDIC sine, folded into the first quadrant and clamped
	function automatic logic signed [63:0] sine_q30(input logic signed [63:0] th);
		logic signed [63:0] x, y, z, dx, dy;
		x = GAIN_INV;
		y = 0;
		if (th > ARC_HALF_PI)
			th = ARC_PI - th;
		z = th;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= 64'(arc_q30(i));
			end else begin
				x += dx; y -= dy; z += 64'(arc_q30(i));
			end
		end
		if (y < 0) y = 0;
		if (y > ARC_ONE) y = ARC_ONE;
		return y;
	endfunction

	function automatic slerp_result_t slerp_predict(input logic [143:0] item);
		slerp_result_t r;
		logic signed [63:0] f[4], g[4], u[4], d, s, alpha, th1, th2, s1, s2;
		logic [63:0] a[4], amax, sumsq, len, mag, qv, t;
		int k;
		d = 0;
		amax = 0;
		sumsq = 0;
		t = 64'(item[143:128]);
		if (t > 64'(BLEND_ONE)) t = 64'(BLEND_ONE);
		for (int i = 0; i < 4; i++) begin
			f[i] = 64'(signed'(item[16*i +: 16]));
			g[i] = 64'(signed'(item[64 + 16*i +: 16]));
			d += (f[i] * g[i]) <<< 2;
		end
		if (d > ARC_ONE) d = ARC_ONE;
		if (d < -ARC_ONE) d = -ARC_ONE;
		s = signed'(root_floor((64'd1 << 60) - 64'(d * d)));
		if (s == 0)
			alpha = (d > 0) ? 64'sd0 : ARC_PI;
		else if (d >= 0)
			alpha = arc_angle(d, s, 0);
		else
			alpha = arc_angle(s, -d, ARC_HALF_PI);
		if (alpha < 0) alpha = 0;
		if (alpha > ARC_PI) alpha = ARC_PI;
		if (alpha < TINY_ARC || s == 0) begin
			for (int i = 0; i < 4; i++)
				r.q[i] = f[i][15:0];
			r.status = (alpha < TINY_ARC) ? ST_NEAR : ST_OPPOSITE;
			return r;
		end
		th2 = signed'((64'(alpha) * t) >> 15);
		th1 = alpha - th2;
		s1 = sine_q30(th1);
		s2 = sine_q30(th2);
		for (int i = 0; i < 4; i++) begin
			u[i] = s1 * f[i] + s2 * g[i];
			a[i] = (u[i] < 0) ? 64'(-u[i]) : 64'(u[i]);
			if (a[i] > amax) amax = a[i];
		end
		k = 0;
		while (k < 63 && (amax >> k) >= (64'd1 << 30))
			k++;
		for (int i = 0; i < 4; i++) begin
			a[i] >>= k;
			sumsq += a[i] * a[i];
		end
		len = root_floor(sumsq);
		mag = (len << k) << 16;
		r.status = ST_INTERP;
		if (len == 0 || mag <= 64'd10737 * 64'(s)) begin
			r.q = '0;
			return r;
		end
		for (int i = 0; i < 4; i++) begin
			qv = ((a[i] << 14) + len / 2) / len;
			r.q[i] = (u[i] < 0) ? 16'(-qv) : 16'(qv);
		end
		return r;
	endfunction

	class slerp_scoreboard;
		slerp_result_t pending[$];
		int mismatches = 0;

		function void note_item(logic [143:0] item);
			pending.push_back(slerp_predict(item));
		endfunction

		function void check_result(logic [63:0] data, logic [1:0] user);
			slerp_result_t e;
			bit bad;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h status %0d", data, user);
				return;
			end
			e = pending.pop_front();
			bad = (user != e.status);
			for (int i = 0; i < 4; i++)
				if (data[16*i +: 16] != e.q[i]) bad = 1;
			if (bad) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %h status %0d, got %h status %0d",
						e.q, e.status, data, user);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [143:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [63:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;

	int send_idle_pct = 9;
	int recv_idle_pct = 48;
	bit hold_off = 0;
	int idle_cycles = 0;
	slerp_scoreboard board = new();

	quaternion_slerp dut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// check accepted results and note accepted inputs
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				board.note_item(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				board.check_result(m_axis_tdata, m_axis_tuser);
		end
	end

	// drive the receiver's ready
	always @(posedge clk) begin
		if (!arst_n || hold_off)
			m_axis_tready <= 0;
		else
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// count cycles with nothing accepted
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// long receiver hold-off, so the pipeline fills and stalls its input
	initial begin
		wait (arst_n);
		repeat (400) @(posedge clk);
		hold_off = 1;
		repeat (600) @(posedge clk);
		hold_off = 0;
	end

	function automatic logic [15:0] pick_comp();
		case ($urandom_range(9))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'($urandom);
			default: return 16'($signed($urandom_range(32768)) - 16384);
		endcase
	endfunction

	// send one item, idling at random before it
	task automatic send_item(input logic [143:0] item);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= item;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic send_quats(input logic [63:0] f, input logic [63:0] g, input logic [15:0] t);
		send_item({t, g, f});
	endtask

	// unit-ish random quaternion, or its exact negation/copy for special cases
	task automatic send_random();
		logic [63:0] f, g;
		logic [15:0] t;
		int c;
		for (int i = 0; i < 4; i++) begin
			f[16*i +: 16] = pick_comp();
			g[16*i +: 16] = pick_comp();
		end
		c = $urandom_range(19);
		if (c == 0) g = f;
		if (c == 1)
			for (int i = 0; i < 4; i++) g[16*i +: 16] = -f[16*i +: 16];
		case ($urandom_range(7))
			0: t = 0;
			1: t = BLEND_ONE;
			2: t = 16'($urandom);
			default: t = 16'($urandom_range(32768));
		endcase
		send_quats(f, g, t);
	endtask

	localparam logic [15:0] P1 = 16'sd16384;
	localparam logic [15:0] M1 = -16'sd16384;

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: equal, opposite, orthogonal, blend extremes, vanishing sum, raw patterns
		send_quats({48'd0, P1}, {48'd0, P1}, 16'd16384);
		send_quats({48'd0, P1}, {48'd0, M1}, 16'd16384);
		send_quats({48'd0, P1}, {32'd0, P1, 16'd0}, 16'd0);
		send_quats({48'd0, P1}, {32'd0, P1, 16'd0}, BLEND_ONE);
		send_quats({48'd0, P1}, {32'd0, P1, 16'd0}, 16'hFFFF);
		send_quats({48'd0, P1}, {32'd0, P1, 16'd0}, 16'd16384);
		send_quats({M1, M1, M1, M1}, {P1, P1, P1, P1}, 16'd8000);
		send_quats({P1, 16'd0, 16'd0, 16'd0}, {16'd0, P1, 16'd0, 16'd0}, 16'd30000);
		send_quats('0, '0, 16'd16384);
		send_quats({48'd0, 16'sd16000}, {48'd0, 16'sd16001}, 16'd100);
		send_quats({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000},
			{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001}, 16'h8001);
		send_quats({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
			{16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0}, 16'h7FFF);
		send_quats({16'd0, 16'd0, 16'sd11585, 16'sd11585},
			{16'd0, 16'd0, -16'sd11585, 16'sd11585}, 16'd1);
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 3) begin
				send_idle_pct = 48;
				recv_idle_pct = 9;
			end else if (n == 2 * N_RANDOM / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			send_random();
		end
		s_axis_tvalid <= 0;
		wait (board.pending.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (board.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[filelist.f]
rtl/qslp_pkg.sv
rtl/qslp_isqrt.sv
rtl/qslp_cordic.sv
rtl/quaternion_slerp.sv
rtl/qslp_check.sv
verif/tb_quaternion_slerp.sv
